// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfp_pkg
// Types and constants of the ring-buffered ASCII frame parser.
// ----------------------------------------------------------------------------
package rbfp_pkg;

    // Ring geometry (depth is a power of two, pointers wrap naturally)
    localparam int RING_DEPTH = 128;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Frame constants
    localparam logic [7:0] HEADER_RESET  = 8'd65;   // 'A'
    localparam logic [7:0] TRAILER_RESET = 8'd90;   // 'Z'
    localparam logic [7:0] ASCII_ZERO    = 8'd48;   // '0'
    localparam logic [7:0] LEN_MAX       = 8'd9;
    localparam logic [3:0] FRAME_OVERHEAD = 4'd3;
    localparam logic [3:0] MIN_FRAME     = 4'd4;
    localparam logic [3:0] PAYLOAD_START = 4'd3;   // offset of first value digit
    localparam logic [3:0] OP_OFFSET     = 4'd2;

    // Commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 1'b1;

    // Input item
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_t;

    // Result item
    typedef struct packed {
        logic               accepted;
        logic [7:0]         op_char;
        logic signed [31:0] value;
        logic [3:0]         frame_length;
    } out_t;

endpackage

// ===== hw/rtl/ring_buffered_ascii_frame_parser_unit.sv =====
// Push: the result is loaded into the output register at the accepting edge.
// Poll: a header, length or trailer mismatch drops one byte and rechecks; a found frame
// steps through check, header, length, trailer, op, one accumulate per value digit; a
// short ring ends at check, a partial frame at length; one read per cycle, single port.
// One item is in flight at a time; a poll holds stall high until its result is loaded.
// Reset clears the pointers and restores header 'A' and trailer 'Z'; ring not cleared.
// ----------------------------------------------------------------------------
// ring_buffered_ascii_frame_parser_unit
// Ring store of received bytes with a sequenced frame scanner that shares one
// memory read port and one multiply-accumulate unit for the decimal value.
// ----------------------------------------------------------------------------
module ring_buffered_ascii_frame_parser_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rbfp_pkg::in_t                      in_data,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output rbfp_pkg::out_t                     out_data,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data
);
    import rbfp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK  = 8'b0000_0010,
        S_HDR  = 8'b0000_0100,
        S_LEN  = 8'b0000_1000,
        S_TRL  = 8'b0001_0000,
        S_OP   = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [7:0]        header_reg, trailer_reg;
    logic [PTR_W-1:0]  raddr;
    logic [7:0]        rdata_reg;
    logic [7:0]        mem [RING_DEPTH];
    logic              mem_we;
    logic [3:0]        total_reg, total_next;
    logic [3:0]        idx_reg, idx_next;
    logic [31:0]       val_reg, val_next;
    logic [7:0]        op_reg, op_next;
    logic              acc_reg, acc_next;
    logic [3:0]        flen_reg, flen_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    logic [PTR_W-1:0]  held;
    logic              in_xfer;
    logic              out_free;
    logic [7:0]        len_full;
    logic              len_ok;
    logic [3:0]        len_total;
    logic [3:0]        idx_inc;
    logic [31:0]       mac;

    // Handshake
    assign held      = wp_reg - rp_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Shared datapath: length decode, index step, value multiply-accumulate
    assign len_full  = rdata_reg - ASCII_ZERO;
    assign len_ok    = (len_full != 8'd0) && (len_full <= LEN_MAX);
    assign len_total = len_full[3:0] + FRAME_OVERHEAD;
    assign idx_inc   = idx_reg + 4'd1;
    assign mac       = (val_reg << 3) + (val_reg << 1) + {24'd0, rdata_reg}
                       - {24'd0, ASCII_ZERO};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        raddr          = rp_reg;
        mem_we         = 1'b0;
        total_next     = total_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        flen_next      = flen_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.command == CMD_PUSH)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next              = '0;
                        if (held != PTR_W'(RING_DEPTH - 1))
                        begin
                            mem_we                  = 1'b1;
                            wp_next                 = wp_reg + 1'b1;
                            out_data_next.accepted  = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next   = 1'b0;
                        op_next    = '0;
                        val_next   = '0;
                        flen_next  = '0;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                // read byte at the read pointer, or give up when too few held
                raddr = rp_reg;
                if (held < PTR_W'(MIN_FRAME))
                    state_next = S_DONE;
                else
                    state_next = S_HDR;
            end
            S_HDR:
            begin
                if (rdata_reg != header_reg)
                begin
                    rp_next    = rp_reg + 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    raddr      = rp_reg + 1'b1;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (!len_ok)
                begin
                    rp_next    = rp_reg + 1'b1;
                    state_next = S_CHK;
                end
                else if (held < PTR_W'(len_total))
                begin
                    // frame not complete yet: keep its start
                    state_next = S_DONE;
                end
                else
                begin
                    total_next = len_total;
                    raddr      = rp_reg + PTR_W'(len_total - 4'd1);
                    state_next = S_TRL;
                end
            end
            S_TRL:
            begin
                if (rdata_reg != trailer_reg)
                begin
                    rp_next    = rp_reg + 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    raddr      = rp_reg + PTR_W'(OP_OFFSET);
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                op_next   = rdata_reg;
                acc_next  = 1'b1;
                flen_next = total_reg;
                idx_next  = PAYLOAD_START;
                if (PAYLOAD_START + 4'd1 < total_reg)
                begin
                    raddr      = rp_reg + PTR_W'(PAYLOAD_START);
                    state_next = S_ACC;
                end
                else
                begin
                    rp_next    = rp_reg + PTR_W'(total_reg);
                    state_next = S_DONE;
                end
            end
            S_ACC:
            begin
                val_next = mac;
                idx_next = idx_inc;
                if (idx_inc + 4'd1 < total_reg)
                begin
                    raddr = rp_reg + PTR_W'(idx_inc);
                end
                else
                begin
                    rp_next    = rp_reg + PTR_W'(total_reg);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.accepted     = acc_reg;
                    out_data_next.op_char      = op_reg;
                    out_data_next.value        = $signed(val_reg);
                    out_data_next.frame_length = flen_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= in_data.data_byte;
        rdata_reg <= mem[raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            header_reg    <= HEADER_RESET;
            trailer_reg   <= TRAILER_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HEADER:  header_reg  <= cfg_data;
                    CFG_TRAILER: trailer_reg <= cfg_data;
                    default:     header_reg  <= header_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        op_reg       <= op_next;
        acc_reg      <= acc_next;
        flen_reg     <= flen_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/rbfp_checker.sv =====
// ----------------------------------------------------------------------------
// rbfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbfp_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  rbfp_pkg::in_t                      in_data,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  rbfp_pkg::out_t                     out_data
);
    import rbfp_pkg::*;

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

    // A push transfer shows its result on the next cycle
    `ASSERT_NEXT(a_push_result, in_valid && !in_stall && in_data.command == CMD_PUSH, out_valid, "push result missing")

    // A poll keeps the input side busy while it scans
    `ASSERT_NEXT(a_poll_busy, in_valid && !in_stall && in_data.command == CMD_POLL, in_stall, "input taken during scan")

    // A refused or empty result carries zeros
    `ASSERT_IMPLIES(a_zero_fields, out_valid && !out_data.accepted, out_data.op_char == 8'd0 && out_data.value == 32'sd0 && out_data.frame_length == 4'd0, "nonzero fields on refused result")

    // A consumed frame spans four to twelve bytes
    `ASSERT_IMPLIES(a_frame_len, out_valid && out_data.frame_length != 4'd0, out_data.accepted && out_data.frame_length >= MIN_FRAME && out_data.frame_length <= 4'd12, "bad frame length")

endmodule

bind ring_buffered_ascii_frame_parser_unit rbfp_checker u_rbfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring-buffered ASCII frame parser. A directed
// table covers reset values, the field extremes, a wrapped value, broken and
// incomplete frames. Random frames, noise and a ring fill follow, under
// several header/trailer settings. Each result is checked against its
// table row where one is given, else an in-bench copy of the ring and scanner.
// ----------------------------------------------------------------------------
module tb_top;
    import rbfp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;

    // one row of the directed stimulus table
    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // bench copy of the parser state
    logic [7:0]       ring_copy [RING_DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [7:0]       hdr_byte;
    logic [7:0]       trl_byte;

    out_t     results_due [$];
    dir_row_t directed_rows [$];

    int gap_max       = 4;
    int stall_max     = 4;
    int item_count    = 0;
    int push_count    = 0;
    int refused_count = 0;
    int poll_count    = 0;
    int frame_count   = 0;
    int cfg_count     = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    ring_buffered_ascii_frame_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // bytes currently held in the ring
    function automatic int held_bytes();
        logic [PTR_W-1:0] diff;
        diff = wr_ptr - rd_ptr;
        return int'(diff);
    endfunction

    // byte at an offset from the read pointer
    function automatic logic [7:0] ring_at(input int offset);
        logic [PTR_W-1:0] addr;
        addr = rd_ptr + PTR_W'(offset);
        return ring_copy[addr];
    endfunction

    // push a byte or scan for one frame; returns the result the block owes
    function automatic out_t parse_step(input in_t item);
        out_t             res;
        logic [7:0]       len;
        logic [31:0]      acc;
        int               total;
        bit               done;
        res  = '0;
        done = 1'b0;
        if (item.command == CMD_PUSH)
        begin
            push_count++;
            if (held_bytes() < RING_DEPTH - 1)
            begin
                ring_copy[wr_ptr] = item.data_byte;
                wr_ptr            = wr_ptr + 1'b1;
                res.accepted      = 1'b1;
            end
            else
                refused_count++;
            return res;
        end
        poll_count++;
        while (!done && held_bytes() >= int'(MIN_FRAME))
        begin
            len   = ring_at(1) - ASCII_ZERO;
            total = int'(len) + int'(FRAME_OVERHEAD);
            if (ring_at(0) != hdr_byte || len < 8'd1 || len > LEN_MAX)
                rd_ptr = rd_ptr + 1'b1;
            else if (held_bytes() < total)
                done = 1'b1;                        // keep the partial frame
            else if (ring_at(total - 1) != trl_byte)
                rd_ptr = rd_ptr + 1'b1;
            else
            begin
                acc = '0;
                for (int i = int'(PAYLOAD_START); i + 1 < total; i++)
                    acc = acc * 32'd10 + {24'd0, ring_at(i)} - {24'd0, ASCII_ZERO};
                res.accepted     = 1'b1;
                res.op_char      = ring_at(int'(OP_OFFSET));
                res.value        = acc;
                res.frame_length = total[3:0];
                rd_ptr           = rd_ptr + PTR_W'(total);
                frame_count++;
                done = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic in_t make_item(input logic cmd, input logic [7:0] b);
        in_t item;
        item.command   = cmd;
        item.data_byte = b;
        return item;
    endfunction

    function automatic dir_row_t dir_row(input logic cmd, input logic [7:0] b,
                                         input bit typed, input logic acc,
                                         input logic [7:0] op,
                                         input logic signed [31:0] val,
                                         input logic [3:0] len);
        dir_row_t row;
        row.item               = make_item(cmd, b);
        row.typed              = typed;
        row.want.accepted      = acc;
        row.want.op_char       = op;
        row.want.value         = val;
        row.want.frame_length  = len;
        return row;
    endfunction

    // one input transfer; called and returns at a falling edge
    task automatic send_item(input in_t item, input bit typed, input out_t want);
        int   gap;
        out_t pred;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        pred = parse_step(item);
        results_due.push_back(typed ? want : pred);
        item_count++;
        @(negedge clk);
    endtask

    task automatic push_once(input logic [7:0] b);
        send_item(make_item(CMD_PUSH, b), 1'b0, '0);
    endtask

    task automatic poll_once();
        send_item(make_item(CMD_POLL, 8'($urandom)), 1'b0, '0);
    endtask

    // hold off the sender until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (results_due.size() != 0);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_HEADER)
            hdr_byte = val;
        else
            trl_byte = val;
        cfg_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed frames, some broken ones, noise and stray polls
    task automatic random_phase(input int n_items);
        logic [7:0] frame_q [$];
        int         target;
        int         pick;
        int         plen;
        int         cut;
        target = item_count + n_items;
        while (item_count < target)
        begin
            pick = $urandom_range(0, 99);
            frame_q.delete();
            if (pick < 75)
            begin
                plen = $urandom_range(1, 9);
                frame_q.push_back(hdr_byte);
                frame_q.push_back(ASCII_ZERO + 8'(plen));
                frame_q.push_back(8'($urandom));
                for (int i = 1; i < plen; i++)
                    frame_q.push_back(($urandom_range(0, 7) != 0) ?
                                      ASCII_ZERO + 8'($urandom_range(0, 9)) :
                                      8'($urandom));
                frame_q.push_back(trl_byte);
                // broken frames: bad length digit, wrong trailer, cut short
                if (pick >= 57)
                begin
                    case (pick % 3)
                        0:
                        begin
                            if ($urandom_range(0, 2) == 0)
                                frame_q[1] = ASCII_ZERO;
                            else if ($urandom_range(0, 1) == 0)
                                frame_q[1] = ASCII_ZERO + 8'd10;
                            else
                                frame_q[1] = 8'($urandom);
                        end
                        1: frame_q[frame_q.size() - 1] = trl_byte ^ 8'($urandom_range(1, 255));
                        default: frame_q.pop_back();
                    endcase
                end
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
            end
            // sometimes poll part way through the frame
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, frame_q.size()) : -1;
            foreach (frame_q[i])
            begin
                if (i == cut)
                    poll_once();
                push_once(frame_q[i]);
            end
            if (pick < 75 || pick >= 90)
                poll_once();
            if ($urandom_range(0, 99) == 0)
                wait_drained();
        end
    endtask

    // result receiver with random stall
    initial
    begin : result_sink
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each result transfer with the oldest one due
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none due: acc %0b op %0h value %0d len %0d",
                         $time, out_data.accepted, out_data.op_char,
                         out_data.value, out_data.frame_length);
            end
            else
            begin
                want = results_due.pop_front();
                if (out_data.accepted !== want.accepted)
                begin
                    error_count++;
                    $display("%0t: accepted expected %0b got %0b",
                             $time, want.accepted, out_data.accepted);
                end
                if (out_data.op_char !== want.op_char)
                begin
                    error_count++;
                    $display("%0t: op_char expected %0h got %0h",
                             $time, want.op_char, out_data.op_char);
                end
                if (out_data.value !== want.value)
                begin
                    error_count++;
                    $display("%0t: value expected %0d got %0d",
                             $time, want.value, out_data.value);
                end
                if (out_data.frame_length !== want.frame_length)
                begin
                    error_count++;
                    $display("%0t: frame_length expected %0d got %0d",
                             $time, want.frame_length, out_data.frame_length);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [7:0] pick_hdr;
        int         held_before;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rd_ptr    = '0;
        wr_ptr    = '0;
        hdr_byte  = HEADER_RESET;
        trl_byte  = TRAILER_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, reset header 'A' and trailer 'Z'
        directed_rows.push_back(dir_row(CMD_POLL, 8'h00, 1, 0, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "A",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "1",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "X",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "Z",   1, 1, 8'h00, 0, 4'd0));
        // shortest frame, one-byte payload gives value 0
        directed_rows.push_back(dir_row(CMD_POLL, 8'hFF, 1, 1, "X",   0, 4'd4));
        // stray zero byte, then the start of a nine-byte payload
        directed_rows.push_back(dir_row(CMD_PUSH, 8'h00, 1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "A",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "9",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "*",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, 8'hFF, 1, 1, 8'h00, 0, 4'd0));
        // incomplete frame: nothing reported, start kept
        directed_rows.push_back(dir_row(CMD_POLL, 8'h00, 1, 0, 8'h00, 0, 4'd0));
        for (int i = 0; i < 7; i++)
            directed_rows.push_back(dir_row(CMD_PUSH, 8'hFF, 1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "Z",   1, 1, 8'h00, 0, 4'd0));
        // longest frame, non-digit payload wraps the value
        directed_rows.push_back(dir_row(CMD_POLL, 8'h00, 0, 0, 8'h00, 0, 4'd0));
        // bad length digit, then a wrong trailer
        directed_rows.push_back(dir_row(CMD_PUSH, "A",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "A",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "1",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "q",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_PUSH, "Y",   1, 1, 8'h00, 0, 4'd0));
        directed_rows.push_back(dir_row(CMD_POLL, 8'h00, 1, 0, 8'h00, 0, 4'd0));
        // fewer than four bytes held
        directed_rows.push_back(dir_row(CMD_POLL, 8'hFF, 1, 0, 8'h00, 0, 4'd0));
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // random traffic under the reset framing bytes
        random_phase(220);

        // extreme framing bytes, no idling on either side
        write_reg(CFG_HEADER, 8'h00);
        write_reg(CFG_TRAILER, 8'hFF);
        gap_max   = 0;
        stall_max = 0;
        random_phase(200);

        write_reg(CFG_HEADER, 8'hFF);
        write_reg(CFG_TRAILER, 8'h00);
        gap_max   = 4;
        stall_max = 4;
        random_phase(200);

        // fill the ring past capacity, then drain it by polling until a poll
        // leaves the ring as it was (short ring or a partial frame kept)
        write_reg(CFG_HEADER, 8'($urandom));
        write_reg(CFG_TRAILER, 8'($urandom));
        repeat (RING_DEPTH + 8) push_once(8'($urandom));
        do
        begin
            held_before = held_bytes();
            poll_once();
        end
        while (held_bytes() >= int'(MIN_FRAME) && held_bytes() != held_before);
        poll_once();

        // header and trailer equal
        pick_hdr = 8'($urandom);
        write_reg(CFG_HEADER, pick_hdr);
        write_reg(CFG_TRAILER, pick_hdr);
        stall_max = 0;
        random_phase(200);

        write_reg(CFG_HEADER, 8'($urandom));
        write_reg(CFG_TRAILER, 8'($urandom));
        gap_max   = 0;
        stall_max = 4;
        random_phase(200);

        write_reg(CFG_HEADER, HEADER_RESET);
        write_reg(CFG_TRAILER, TRAILER_RESET);
        gap_max = 4;
        random_phase(150);

        // wrap up
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d items: %0d pushes (%0d refused on a full ring), %0d polls, %0d frames.",
                 item_count, push_count, refused_count, poll_count, frame_count);
        $display("Framing bytes rewritten %0d times; %0d mismatches seen.",
                 cfg_count, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rbfp_pkg.sv
hw/rtl/ring_buffered_ascii_frame_parser_unit.sv
hw/rtl/rbfp_checker.sv
sim/tb_top.sv
